// ----- design/lsp_pkg.sv -----
// Shared types, widths and codes for the line segment point and projection block.
`timescale 1ns / 1ps

package lsp_pkg;

    // Field widths
    localparam int COORD_W     = 32;
    localparam int COORD_FRAC  = 16;
    localparam int GAMMA_FRAC  = 16;
    localparam int GAMMA_IN_W  = GAMMA_FRAC + 2;
    localparam int GAMMA_OUT_W = GAMMA_FRAC + 1;

    // Internal widths
    localparam int DIFF_W    = COORD_W + 1;        // difference of two coordinates
    localparam int PROD_W    = 2 * DIFF_W;         // full signed lane product
    localparam int SQ_W      = 2 * COORD_W;        // one squared delta component
    localparam int DEN_W     = 2 * COORD_W + 2;    // sum of three squares
    localparam int REM_W     = DEN_W + 1;          // doubled partial remainder
    localparam int SUM2_W    = PROD_W + 1;         // sum of two lane products
    localparam int NUM_W     = PROD_W + 2;         // dot product
    localparam int PT_W      = COORD_W + 3;        // start plus scaled delta
    localparam int DIV_STEPS = GAMMA_FRAC;         // one quotient bit per stage

    // Configuration port
    localparam int CFG_IDX_W = 3;

    localparam logic [GAMMA_OUT_W-1:0] GAMMA_ONE = GAMMA_OUT_W'(1) << GAMMA_FRAC;
    localparam logic [COORD_W-1:0]     COORD_ONE = COORD_W'(1) << COORD_FRAC;

    localparam logic [2:0][COORD_W-1:0] START_RESET = '0;
    localparam logic [2:0][COORD_W-1:0] END_RESET   = {COORD_W'(0), COORD_W'(0), COORD_ONE};

    // Saturation bounds at the widened point width
    localparam logic signed [PT_W-1:0] PT_MAX =
        {{(PT_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam logic signed [PT_W-1:0] PT_MIN =
        {{(PT_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        CMD_EVAL = 1'b0,
        CMD_PROJ = 1'b1
    } cmd_t;

    typedef enum logic {
        STATUS_OK    = 1'b0,
        STATUS_DEGEN = 1'b1
    } status_t;

    typedef logic [COORD_W-1:0]     coord_t;
    typedef logic [DIFF_W-1:0]      diff_t;
    typedef logic [PROD_W-1:0]      prod_t;
    typedef logic [GAMMA_OUT_W-1:0] gamma_t;

    // Segment as seen by the datapath
    typedef struct packed {
        logic [2:0][COORD_W-1:0] start;
        logic [2:0][DIFF_W-1:0]  delta;
        logic [DEN_W-1:0]        den;
        logic                    degen;
    } seg_t;

    typedef struct packed {
        cmd_t                   cmd;
        gamma_t                 gamma;
        logic                   clamped;
        logic [2:0][DIFF_W-1:0] vec;
    } s1_t;

    typedef struct packed {
        cmd_t                   cmd;
        gamma_t                 gamma;
        logic                   clamped;
        logic [2:0][PROD_W-1:0] prod;
    } s2_t;

    typedef struct packed {
        cmd_t                    cmd;
        gamma_t                  gamma;
        logic                    clamped;
        logic [2:0][COORD_W-1:0] point;
        logic [SUM2_W-1:0]       part;
        prod_t                   last;
    } s3_t;

    typedef struct packed {
        cmd_t                    cmd;
        gamma_t                  gamma;
        logic                    clamped;
        logic [2:0][COORD_W-1:0] point;
        logic [NUM_W-1:0]        num;
    } front_t;

    typedef struct packed {
        gamma_t                  gamma;
        logic                    clamped;
        logic [2:0][COORD_W-1:0] point;
        logic                    div_en;
        logic [REM_W-1:0]        rem;
        logic [GAMMA_FRAC-1:0]   quo;
    } quo_stage_t;

    typedef struct packed {
        gamma_t                  gamma;
        logic [2:0][COORD_W-1:0] point;
        logic                    clamped;
        status_t                 status;
    } res_t;

endpackage

// ----- design/lsp_if.sv -----
// Handshake interfaces for the configuration, query and result channels.
`timescale 1ns / 1ps

interface lsp_cfg_if import lsp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface lsp_in_if import lsp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [GAMMA_IN_W-1:0] gamma_in;
    logic signed [COORD_W-1:0]    coord_x;
    logic signed [COORD_W-1:0]    coord_y;
    logic signed [COORD_W-1:0]    coord_z;

    modport source (output valid, output cmd, output gamma_in, output coord_x,
                    output coord_y, output coord_z, input ready);
    modport sink   (input valid, input cmd, input gamma_in, input coord_x,
                    input coord_y, input coord_z, output ready);
endinterface

interface lsp_out_if import lsp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [GAMMA_OUT_W-1:0]    gamma_out;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      was_clamped;
    logic                      status;

    modport source (output valid, output gamma_out, output point_x, output point_y,
                    output point_z, output was_clamped, output status, input ready);
    modport sink   (input valid, input gamma_out, input point_x, input point_y,
                    input point_z, input was_clamped, input status, output ready);
endinterface

// ----- design/lsp_cfg.sv -----
// Segment registers and the derived delta, squared length and degenerate flag.
`timescale 1ns / 1ps

module lsp_cfg import lsp_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    lsp_cfg_if.sink cfg,
    output seg_t  seg
);

    logic [2:0][COORD_W-1:0] start_pt_reg, start_pt_next;
    logic [2:0][COORD_W-1:0] end_pt_reg, end_pt_next;
    logic [2:0][DIFF_W-1:0]  delta_reg;
    logic [2:0][SQ_W-1:0]    sq_reg;
    logic [DEN_W-1:0]        den_part_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    degen_reg;
    logic signed [PROD_W-1:0] sq_full [3];

    // Take every write at once
    assign cfg.ready = 1'b1;

    // Decode the register index; drop writes beyond the list
    always_comb
    begin
        start_pt_next = start_pt_reg;
        end_pt_next   = end_pt_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_START_X: start_pt_next[0] = cfg.data;
                REG_START_Y: start_pt_next[1] = cfg.data;
                REG_START_Z: start_pt_next[2] = cfg.data;
                REG_END_X:   end_pt_next[0]   = cfg.data;
                REG_END_Y:   end_pt_next[1]   = cfg.data;
                REG_END_Z:   end_pt_next[2]   = cfg.data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pt_reg <= START_RESET;
            end_pt_reg   <= END_RESET;
        end
        else
        begin
            start_pt_reg <= start_pt_next;
            end_pt_reg   <= end_pt_next;
        end
    end

    // Square each delta component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_full[i] = $signed(delta_reg[i]) * $signed(delta_reg[i]);
        end
    end

    // Derived values follow the registers, one step per cycle
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            delta_reg[i] <= DIFF_W'($signed(end_pt_reg[i])) - DIFF_W'($signed(start_pt_reg[i]));
            sq_reg[i]    <= sq_full[i][SQ_W-1:0];
        end
        degen_reg    <= (delta_reg == '0);
        den_part_reg <= DEN_W'(sq_reg[0]) + DEN_W'(sq_reg[1]);
        den_reg      <= den_part_reg + DEN_W'(sq_reg[2]);
    end

    assign seg.start = start_pt_reg;
    assign seg.delta = delta_reg;
    assign seg.den   = den_reg;
    assign seg.degen = degen_reg;

endmodule

// ----- design/lsp_front.sv -----
// Front pipeline: clamp and difference, lane multiply, point and partial dot sum, dot product.
`timescale 1ns / 1ps

module lsp_front import lsp_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    lsp_in_if.sink query,
    input  seg_t   seg,
    output logic   out_valid,
    input  logic   out_ready,
    output front_t out_data
);

    logic   s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic   s1_ready, s2_ready, s3_ready, s4_ready;
    s1_t    s1_reg, s1_next;
    s2_t    s2_reg, s2_next;
    s3_t    s3_reg, s3_next;
    front_t s4_reg, s4_next;

    // Each stage takes a new transaction when empty or when it empties downstream
    assign s4_ready    = !s4_valid_reg || out_ready;
    assign s3_ready    = !s3_valid_reg || s4_ready;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign query.ready = s1_ready;

    // Stage 1: clamp gamma, subtract the segment start from the query point
    always_comb
    begin
        s1_next.cmd = cmd_t'(query.cmd);
        if (query.gamma_in < 0)
        begin
            s1_next.gamma   = '0;
            s1_next.clamped = 1'b1;
        end
        else if ($signed(query.gamma_in) > $signed({1'b0, GAMMA_ONE}))
        begin
            s1_next.gamma   = GAMMA_ONE;
            s1_next.clamped = 1'b1;
        end
        else
        begin
            s1_next.gamma   = query.gamma_in[GAMMA_OUT_W-1:0];
            s1_next.clamped = 1'b0;
        end
        s1_next.vec[0] = DIFF_W'($signed(query.coord_x)) - DIFF_W'($signed(seg.start[0]));
        s1_next.vec[1] = DIFF_W'($signed(query.coord_y)) - DIFF_W'($signed(seg.start[1]));
        s1_next.vec[2] = DIFF_W'($signed(query.coord_z)) - DIFF_W'($signed(seg.start[2]));
    end

    // Stage 2: one multiplier per lane, delta times gamma or delta times offset
    always_comb
    begin
        diff_t                    mul_b;
        logic signed [PROD_W-1:0] prod_w;
        mul_b  = '0;
        prod_w = '0;
        s2_next.cmd     = s1_reg.cmd;
        s2_next.gamma   = s1_reg.gamma;
        s2_next.clamped = s1_reg.clamped;
        for (int i = 0; i < 3; i++)
        begin
            mul_b  = (s1_reg.cmd == CMD_PROJ) ? s1_reg.vec[i] : DIFF_W'(s1_reg.gamma);
            prod_w = $signed(seg.delta[i]) * $signed(mul_b);
            s2_next.prod[i] = prod_w;
        end
    end

    // Stage 3: floor-scale and saturate the point, add the first two dot terms
    always_comb
    begin
        logic signed [PT_W-1:0] lerp_v;
        logic signed [PT_W-1:0] sum_v;
        lerp_v = '0;
        sum_v  = '0;
        s3_next.cmd     = s2_reg.cmd;
        s3_next.gamma   = s2_reg.gamma;
        s3_next.clamped = s2_reg.clamped;
        for (int i = 0; i < 3; i++)
        begin
            lerp_v = PT_W'($signed(s2_reg.prod[i]) >>> GAMMA_FRAC);
            sum_v  = PT_W'($signed(seg.start[i])) + lerp_v;
            if (sum_v > PT_MAX)
            begin
                s3_next.point[i] = PT_MAX[COORD_W-1:0];
            end
            else if (sum_v < PT_MIN)
            begin
                s3_next.point[i] = PT_MIN[COORD_W-1:0];
            end
            else
            begin
                s3_next.point[i] = sum_v[COORD_W-1:0];
            end
        end
        s3_next.part = SUM2_W'($signed(s2_reg.prod[0])) + SUM2_W'($signed(s2_reg.prod[1]));
        s3_next.last = s2_reg.prod[2];
    end

    // Stage 4: finish the dot product
    always_comb
    begin
        s4_next.cmd     = s3_reg.cmd;
        s4_next.gamma   = s3_reg.gamma;
        s4_next.clamped = s3_reg.clamped;
        s4_next.point   = s3_reg.point;
        s4_next.num     = NUM_W'($signed(s3_reg.part)) + NUM_W'($signed(s3_reg.last));
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= query.valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    // Hold stalled payload, advance otherwise
    always_ff @(posedge clk)
    begin
        if (s1_ready) s1_reg <= s1_next;
        if (s2_ready) s2_reg <= s2_next;
        if (s3_ready) s3_reg <= s3_next;
        if (s4_ready) s4_reg <= s4_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_reg;

    // An accepted transaction lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        query.valid && query.ready |=> s1_valid_reg)
        else $error("accepted transaction missing from first stage");

    // A stalled first stage keeps its transaction untouched
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_reg))
        else $error("stalled first stage overwritten");

endmodule

// ----- design/lsp_div.sv -----
// Projection range check, pipelined restoring divider and result register.
`timescale 1ns / 1ps

module lsp_div import lsp_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  seg_t   seg,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output res_t   out_data
);

    logic                 cmp_valid_reg;
    logic                 cmp_ready;
    quo_stage_t           cmp_reg, cmp_next;
    logic [DIV_STEPS-1:0] step_valid_reg;
    logic [DIV_STEPS-1:0] step_ready;
    quo_stage_t           step_reg [DIV_STEPS];
    logic                 res_valid_reg;
    logic                 res_ready;
    res_t                 res_reg, res_next;

    // One quotient bit when enabled: double the remainder, subtract the length when it fits
    function automatic quo_stage_t div_step(input quo_stage_t cur, input logic [DEN_W-1:0] den);
        quo_stage_t       nxt;
        logic [REM_W-1:0] dbl;
        logic [REM_W-1:0] dext;
        nxt  = cur;
        dbl  = {cur.rem[REM_W-2:0], 1'b0};
        dext = {1'b0, den};
        if (cur.div_en)
        begin
            if (dbl >= dext)
            begin
                nxt.rem = dbl - dext;
                nxt.quo = {cur.quo[GAMMA_FRAC-2:0], 1'b1};
            end
            else
            begin
                nxt.rem = dbl;
                nxt.quo = {cur.quo[GAMMA_FRAC-2:0], 1'b0};
            end
        end
        return nxt;
    endfunction

    // Ready chain from the result register back to the range check
    always_comb
    begin
        res_ready = !res_valid_reg || out_ready;
        step_ready[DIV_STEPS-1] = !step_valid_reg[DIV_STEPS-1] || res_ready;
        for (int k = DIV_STEPS - 2; k >= 0; k--)
        begin
            step_ready[k] = !step_valid_reg[k] || step_ready[k+1];
        end
        cmp_ready = !cmp_valid_reg || step_ready[0];
    end

    assign in_ready = cmp_ready;

    // Range check: a projection clamps at either end or else starts the division; an evaluation passes through
    always_comb
    begin
        logic             num_neg;
        logic             num_zero;
        logic [NUM_W-1:0] den_ext;
        num_neg  = in_data.num[NUM_W-1];
        num_zero = (in_data.num == '0);
        den_ext  = NUM_W'(seg.den);
        cmp_next.gamma   = in_data.gamma;
        cmp_next.clamped = in_data.clamped;
        cmp_next.point   = in_data.point;
        cmp_next.div_en  = 1'b0;
        cmp_next.rem     = REM_W'(in_data.num[DEN_W-1:0]);
        cmp_next.quo     = '0;
        if (in_data.cmd == CMD_PROJ)
        begin
            cmp_next.point = '0;
            if (num_neg || num_zero)
            begin
                cmp_next.gamma   = '0;
                cmp_next.clamped = num_neg;
            end
            else if (in_data.num >= den_ext)
            begin
                cmp_next.gamma   = GAMMA_ONE;
                cmp_next.clamped = (in_data.num != den_ext);
            end
            else
            begin
                cmp_next.gamma   = '0;
                cmp_next.clamped = 1'b0;
                cmp_next.div_en  = 1'b1;
            end
        end
    end

    // Result: pick the quotient or the passed gamma, zero gamma, point and clamp flag for a degenerate segment
    always_comb
    begin
        quo_stage_t last;
        last = step_reg[DIV_STEPS-1];
        if (seg.degen)
        begin
            res_next.gamma   = '0;
            res_next.point   = '0;
            res_next.clamped = 1'b0;
            res_next.status  = STATUS_DEGEN;
        end
        else
        begin
            res_next.gamma   = last.div_en ? GAMMA_OUT_W'(last.quo) : last.gamma;
            res_next.point   = last.point;
            res_next.clamped = last.clamped;
            res_next.status  = STATUS_OK;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg  <= 1'b0;
            step_valid_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmp_ready) cmp_valid_reg <= in_valid;
            if (step_ready[0]) step_valid_reg[0] <= cmp_valid_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                if (step_ready[k]) step_valid_reg[k] <= step_valid_reg[k-1];
            end
            if (res_ready) res_valid_reg <= step_valid_reg[DIV_STEPS-1];
        end
    end

    // Hold stalled payload, advance otherwise
    always_ff @(posedge clk)
    begin
        if (cmp_ready) cmp_reg <= cmp_next;
        if (step_ready[0]) step_reg[0] <= div_step(cmp_reg, seg.den);
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            if (step_ready[k]) step_reg[k] <= div_step(step_reg[k-1], seg.den);
        end
        if (res_ready) res_reg <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // A degenerate result has zero gamma, zero point and no clamp flag
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status == STATUS_DEGEN |->
            res_reg.gamma == '0 && !res_reg.clamped && res_reg.point == '0)
        else $error("degenerate result carries non-zero fields");

    // A divided projection was never clamped and has no point
    a_div_unclamped: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid_reg[DIV_STEPS-1] && step_reg[DIV_STEPS-1].div_en |->
            !step_reg[DIV_STEPS-1].clamped && step_reg[DIV_STEPS-1].point == '0)
        else $error("divided transaction marked clamped or carries a point");

    // Gamma never exceeds one
    a_gamma_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_reg.gamma <= GAMMA_ONE)
        else $error("gamma above one");

endmodule

// ----- design/line_segment_point_and_projection.sv -----
// Top level of the line segment point evaluation and point projection block.
`timescale 1ns / 1ps

// Takes one query per cycle while the result channel is not stalled and returns one
// result per query, in order, through a front end (clamp and difference, lane
// multiply, point and partial dot sum, dot product), a range-check register,
// sixteen divider stages that each resolve one bit of the Q1.16 gamma, and the
// result register. A stalled result channel fills the pipeline before the query
// channel drops ready. The segment delta, squared length and degenerate flag are
// registered from the configuration in turn (delta, then squares and degenerate
// flag, then partial sum, then squared length) ahead of any transaction that
// reaches the stages using them.
module line_segment_point_and_projection import lsp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    lsp_cfg_if.sink   cfg,
    lsp_in_if.sink    query,
    lsp_out_if.source result
);

    seg_t   seg;
    logic   mid_valid;
    logic   mid_ready;
    front_t mid_data;
    logic   res_valid;
    res_t   res_data;

    // Segment registers
    lsp_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .seg   (seg)
    );

    // Multiply and sum
    lsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query),
        .seg       (seg),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    // Range check, division and result
    lsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg       (seg),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (res_valid),
        .out_ready (result.ready),
        .out_data  (res_data)
    );

    // Drive the result channel from the result register
    assign result.valid       = res_valid;
    assign result.gamma_out   = res_data.gamma;
    assign result.point_x     = res_data.point[0];
    assign result.point_y     = res_data.point[1];
    assign result.point_z     = res_data.point[2];
    assign result.was_clamped = res_data.clamped;
    assign result.status      = res_data.status;

endmodule
